@@ rtl/core/slrb_pkg.sv @@
// ============================================================================
// slrb_pkg: shared types and constants for the serial line ring buffer
// Ring geometry, command and result codes, queue entry and terminator test.
// ============================================================================
package slrb_pkg;

    // Ring slots; one slot stays free, so the ring holds DEPTH-1 bytes
    localparam int DEPTH    = 16384;
    localparam int IDX_W    = $clog2(DEPTH);
    // Largest caller line buffer; a line holds at most MAX_LINE-1 bytes
    localparam int MAX_LINE = 64;
    localparam int LEN_W    = $clog2(MAX_LINE);

    // Command queue between front and back
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_GET  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_CHAR  = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LREAD,
        B_LEVAL,
        B_LDONE,
        B_TREAD,
        B_TEVAL
    } back_state_t;

    // One classified item as queued for the back end
    typedef struct packed {
        cmd_t             cmd;
        logic [7:0]       data;
        logic             batch_end;
        logic [LEN_W-1:0] budget;   // bytes that a get may pop
    } q_entry_t;

    function automatic logic is_term(input logic [7:0] b);
        return (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_NUL);
    endfunction

endpackage

@@ rtl/core/slrb_front.sv @@
// ============================================================================
// slrb_front: input acceptance and command classification
// Decodes the input item and turns max_line into a pop budget.
// ============================================================================
module slrb_front import slrb_pkg::*; (
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,
    input  logic        q_full,
    output logic        q_push,
    output q_entry_t    q_wdata
);

    logic [6:0] max_line;
    logic [6:0] limit;

    assign max_line = s_axis_tdata[14:8];

    // values above MAX_LINE act as MAX_LINE, zero acts as one
    always_comb begin
        if (max_line > 7'(MAX_LINE)) begin
            limit = 7'(MAX_LINE);
        end else if (max_line == 7'd0) begin
            limit = 7'd1;
        end else begin
            limit = max_line;
        end
    end

    assign s_axis_tready     = !q_full;
    assign q_push            = s_axis_tvalid && !q_full;
    assign q_wdata.cmd       = cmd_t'(s_axis_tuser);
    assign q_wdata.data      = s_axis_tdata[7:0];
    assign q_wdata.batch_end = s_axis_tlast;
    assign q_wdata.budget    = LEN_W'(limit - 7'd1);

endmodule

@@ rtl/core/slrb_cmd_fifo.sv @@
// ============================================================================
// slrb_cmd_fifo: short command queue between front and back
// Register FIFO of classified items; head is shown combinationally.
// ============================================================================
module slrb_cmd_fifo import slrb_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t wdata,
    output logic     full,
    input  logic     pop,
    output logic     valid,
    output q_entry_t rdata
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg,  cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign valid   = (cnt_reg != '0);
    assign rdata   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wptr_next = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/slrb_back.sv @@
// ============================================================================
// slrb_back: ring storage, terminator count and line extraction
// Executes queued pushes and get-line requests; drives the result register.
// ============================================================================
module slrb_back import slrb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  q_entry_t    q_entry,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser
);

    logic [7:0]       ring [DEPTH];
    logic [7:0]       rdata_reg;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] tcnt_reg,   tcnt_next;
    logic [LEN_W-1:0] budget_reg, budget_next;
    logic [LEN_W-1:0] n_reg,      n_next;
    logic [7:0]       pend_reg,   pend_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg,  out_kind_next;
    logic [7:0]       out_char_reg,  out_char_next;
    logic [5:0]       out_index_reg, out_index_next;
    logic             out_last_reg,  out_last_next;

    logic [IDX_W-1:0] wr_inc, wr_inc2, rd_inc;
    logic             ring_empty, ring_full, can_emit;
    logic             push_ok, push_term, full_after, head_term;
    logic [IDX_W-1:0] cnt_after, tcnt_dec;
    logic             ram_we, ram_re;
    logic             emit;
    kind_t            emit_kind;
    logic [7:0]       emit_char;
    logic [5:0]       emit_index;
    logic             emit_last;

    assign wr_inc  = (wr_idx_reg == IDX_W'(DEPTH-1)) ? '0 : wr_idx_reg + 1'b1;
    assign wr_inc2 = (wr_inc == IDX_W'(DEPTH-1)) ? '0 : wr_inc + 1'b1;
    assign rd_inc  = (rd_idx_reg == IDX_W'(DEPTH-1)) ? '0 : rd_idx_reg + 1'b1;

    assign ring_empty = (wr_idx_reg == rd_idx_reg);
    assign ring_full  = (wr_inc == rd_idx_reg);
    assign can_emit   = !out_valid_reg || m_axis_tready;
    assign head_term  = is_term(rdata_reg);

    assign push_ok    = !ring_full;
    assign push_term  = push_ok && is_term(q_entry.data);
    assign cnt_after  = tcnt_reg + IDX_W'(push_term);
    assign full_after = push_ok ? (wr_inc2 == rd_idx_reg) : 1'b1;
    assign tcnt_dec   = (tcnt_reg != '0) ? tcnt_reg - 1'b1 : tcnt_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid && can_emit && q_entry.cmd == CMD_GET && tcnt_reg != '0) begin
                    state_next = B_LREAD;
                end
            end
            B_LREAD: begin
                if (budget_reg == '0 || ring_empty) begin
                    state_next = B_LDONE;
                end else begin
                    state_next = B_LEVAL;
                end
            end
            B_LEVAL: begin
                if (head_term) begin
                    state_next = (n_reg == '0) ? B_LREAD : B_LDONE;
                end else if (n_reg == '0 || can_emit) begin
                    state_next = B_LREAD;
                end
            end
            B_LDONE: begin
                if (can_emit) begin
                    state_next = B_TREAD;
                end
            end
            B_TREAD: begin
                state_next = ring_empty ? B_IDLE : B_TEVAL;
            end
            B_TEVAL: begin
                state_next = head_term ? B_TREAD : B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        tcnt_next   = tcnt_reg;
        budget_next = budget_reg;
        n_next      = n_reg;
        pend_next   = pend_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        emit        = 1'b0;
        emit_kind   = KIND_NONE;
        emit_char   = 8'd0;
        emit_index  = 6'd0;
        emit_last   = 1'b1;
        case (state_reg)
            B_IDLE: begin
                if (q_valid && can_emit) begin
                    q_pop = 1'b1;
                    if (q_entry.cmd == CMD_PUSH) begin
                        if (push_ok) begin
                            wr_idx_next = wr_inc;
                            ram_we      = 1'b1;
                            tcnt_next   = cnt_after;
                        end
                        if (q_entry.batch_end) begin
                            if (cnt_after != '0) begin
                                emit      = 1'b1;
                                emit_kind = KIND_EVENT;
                            end else if (full_after) begin
                                // full with no line in it: start over
                                wr_idx_next = '0;
                                rd_idx_next = '0;
                                tcnt_next   = '0;
                            end
                        end
                    end else if (tcnt_reg == '0) begin
                        emit = 1'b1;
                    end else begin
                        budget_next = q_entry.budget;
                        n_next      = '0;
                    end
                end
            end
            B_LREAD: begin
                if (budget_reg != '0 && !ring_empty) begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_inc;
                end
            end
            B_LEVAL: begin
                if (head_term) begin
                    budget_next = budget_reg - 1'b1;
                    tcnt_next   = tcnt_dec;
                end else if (n_reg == '0 || can_emit) begin
                    budget_next = budget_reg - 1'b1;
                    // previous char is not the last one: send it now
                    if (n_reg != '0) begin
                        emit       = 1'b1;
                        emit_kind  = KIND_CHAR;
                        emit_char  = pend_reg;
                        emit_index = 6'(n_reg - 1'b1);
                        emit_last  = 1'b0;
                    end
                    pend_next = rdata_reg;
                    n_next    = n_reg + 1'b1;
                end
            end
            B_LDONE: begin
                if (can_emit) begin
                    emit = 1'b1;
                    if (n_reg != '0) begin
                        emit_kind  = KIND_CHAR;
                        emit_char  = pend_reg;
                        emit_index = 6'(n_reg - 1'b1);
                    end
                end
            end
            B_TREAD: begin
                if (!ring_empty) begin
                    ram_re = 1'b1;
                end
            end
            B_TEVAL: begin
                // drop terminators left at the head
                if (head_term) begin
                    rd_idx_next = rd_inc;
                    tcnt_next   = tcnt_dec;
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_char_next  = out_char_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_char_next  = emit_char;
            out_index_next = emit_index;
            out_last_next  = emit_last;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            tcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            tcnt_reg      <= tcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        budget_reg    <= budget_next;
        n_reg         <= n_next;
        pend_reg      <= pend_next;
        out_kind_reg  <= out_kind_next;
        out_char_reg  <= out_char_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            ring[wr_inc] <= q_entry.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rdata_reg <= ring[rd_inc];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_index_reg, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

@@ rtl/core/serial_line_ring_buffer.sv @@
// ============================================================================
// serial_line_ring_buffer: line-framing receive FIFO for serial text
// Stores received bytes in a ring and hands them back one line at a time.
// ============================================================================
// Usage:
//   Input stream (s_axis_*): tuser selects push (0) or get-line (1). A push
//   stores tdata[7:0]; tlast marks the last byte of a receive batch, which
//   yields one line-ready event if any CR, LF or NUL is held. A get-line uses
//   tdata[14:8] as the caller buffer size and returns the line bytes.
//   Output stream (m_axis_*): one item per result, tlast on the final result
//   of each input item; tuser is the result kind.
//   Back end: a push is stored straight from the idle state; a get-line reads
//   each byte popped through the registered ring read and then evaluates it,
//   then drops trailing terminators the same way, with setup and wrap-up states.
//   A 4-entry command queue lets the input keep accepting while a get runs.
//   Reset empties the ring and the queue; the ring memory needs no clearing.
//   When the receiver stalls, the result register holds and the back end
//   waits; the input side stalls only once the command queue fills.
// ============================================================================
module serial_line_ring_buffer import slrb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [14:8] max_line, [15] zero
    input  logic        s_axis_tlast,   // batch_end
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_value, [13:8] char_index, [15:14] zero
    output logic        m_axis_tlast,   // last_in_run
    output logic [1:0]  m_axis_tuser    // result_kind
);

    logic     q_full;
    logic     q_push;
    q_entry_t q_wdata;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_rdata;

    // decode and classify input items
    slrb_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_wdata       (q_wdata)
    );

    // decouples acceptance from line extraction
    slrb_cmd_fifo u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    // ring, terminator count, line framing and result register
    slrb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_rdata),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
